>>> rtl/rmt_pkg.sv
// ----------------------------------------------------------------------------
// rmt_pkg - running median tracker shared definitions
// Data widths, default capacity and sequencer codes.
// ----------------------------------------------------------------------------
package rmt_pkg;

    localparam int RMT_CAPACITY = 64;
    localparam int RMT_DATA_W   = 32;
    localparam int RMT_CNT_OUT_W = 7;

    localparam int RMT_S_TDATA_W = 40;
    localparam int RMT_M_TDATA_W = 40;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PICK = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    typedef logic signed [RMT_DATA_W-1:0] rmt_data_t;

endpackage

>>> rtl/rmt_cell.sv
// ----------------------------------------------------------------------------
// rmt_cell - one slot of the sorted sample chain
// Keeps its value, takes the new sample, or takes its left neighbor's value,
// so the chain stays in ascending order after each insert. Also drives its
// value onto the median taps when its index is selected.
// ----------------------------------------------------------------------------
module rmt_cell
    import rmt_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 7,
    parameter int IW  = 6
) (
    input  logic          aclk,
    input  logic          ins_en,
    input  rmt_data_t     ins_val,
    input  logic [CW-1:0] occ_count,
    input  logic          left_keep,
    input  rmt_data_t     left_val,
    input  logic [IW-1:0] lo_idx,
    input  logic [IW-1:0] hi_idx,
    output logic          keep,
    output rmt_data_t     val,
    output rmt_data_t     lo_tap,
    output rmt_data_t     hi_tap
);

    rmt_data_t val_reg;
    rmt_data_t val_next;
    logic      occupied;

    assign occupied = (CW'(IDX) < occ_count);
    assign keep     = occupied && (val_reg <= ins_val);
    assign val      = val_reg;

    always_comb begin
        if (keep) begin
            val_next = val_reg;
        end else if (left_keep) begin
            val_next = ins_val;
        end else begin
            val_next = left_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (ins_en) begin
            val_reg <= val_next;
        end
    end

    assign lo_tap = (lo_idx == IW'(IDX)) ? val_reg : '0;
    assign hi_tap = (hi_idx == IW'(IDX)) ? val_reg : '0;

endmodule

>>> rtl/running_median_tracker.sv
// ----------------------------------------------------------------------------
// running_median_tracker - running median over a sorted cell chain
// Each sample is inserted into a chain of sorted cells; the middle cell, or
// for an even count the two middle cells averaged, gives the running median.
//
//  channel | dir | tdata fields (low bit up)                  | width
//  s_      | in  | sample[31:0], restart[32], zero pad        | 40
//  m_      | out | median[31:0], stored_count[38:32], dropped  | 40
//
// Each transaction steps through insert, pick middle cells, form median.
// The next sample is taken once the median reaches the output register.
// aresetn (synchronous) empties the store; cell contents are not cleared.
// A stalled output holds the sequencer in its last step; input waits.
// ----------------------------------------------------------------------------
module running_median_tracker
    import rmt_pkg::*;
#(
    parameter int CAPACITY = RMT_CAPACITY
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [RMT_S_TDATA_W-1:0] s_tdata,   // sample, restart
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [RMT_M_TDATA_W-1:0] m_tdata    // median, stored_count, dropped
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          drop_reg, drop_next;
    rmt_data_t     lo_reg, hi_reg;
    logic          m_valid_reg, m_valid_next;
    rmt_data_t     med_reg;
    logic [RMT_CNT_OUT_W-1:0] cnt_out_reg;
    logic          drop_out_reg;

    logic          accept;
    rmt_data_t     s_sample;
    logic          s_restart;
    logic [CW-1:0] occ_count;
    logic          full;
    logic          ins_en;
    logic [IW-1:0] lo_idx, hi_idx;
    logic          out_load;

    logic          keep_w [CAPACITY];
    rmt_data_t     val_w  [CAPACITY];
    rmt_data_t     lo_tap [CAPACITY];
    rmt_data_t     hi_tap [CAPACITY];
    rmt_data_t     lo_sel, hi_sel;

    logic signed [RMT_DATA_W:0] sum;
    logic signed [RMT_DATA_W:0] sum_adj;
    rmt_data_t     med_calc;
    logic [CW+RMT_CNT_OUT_W-1:0] cnt_ext;

    assign s_sample  = s_tdata[RMT_DATA_W-1:0];
    assign s_restart = s_tdata[RMT_DATA_W];
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;

    assign occ_count = s_restart ? '0 : count_reg;
    assign full      = (occ_count == CW'(CAPACITY));
    assign ins_en    = accept && !full;

    assign hi_idx = IW'(count_reg >> 1);
    assign lo_idx = hi_idx - IW'(1);

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic      lk;
            rmt_data_t lv;
            if (g == 0) begin : g_first
                assign lk = 1'b1;
                assign lv = s_sample;
            end else begin : g_rest
                assign lk = keep_w[g-1];
                assign lv = val_w[g-1];
            end
            rmt_cell #(
                .IDX (g),
                .CW  (CW),
                .IW  (IW)
            ) u_cell (
                .aclk      (aclk),
                .ins_en    (ins_en),
                .ins_val   (s_sample),
                .occ_count (occ_count),
                .left_keep (lk),
                .left_val  (lv),
                .lo_idx    (lo_idx),
                .hi_idx    (hi_idx),
                .keep      (keep_w[g]),
                .val       (val_w[g]),
                .lo_tap    (lo_tap[g]),
                .hi_tap    (hi_tap[g])
            );
        end
    endgenerate

    always_comb begin
        lo_sel = '0;
        hi_sel = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            lo_sel = lo_sel | lo_tap[i];
            hi_sel = hi_sel | hi_tap[i];
        end
    end

    assign sum      = {lo_reg[RMT_DATA_W-1], lo_reg} + {hi_reg[RMT_DATA_W-1], hi_reg};
    assign sum_adj  = sum + {{RMT_DATA_W{1'b0}}, sum[RMT_DATA_W]};
    assign med_calc = count_reg[0] ? hi_reg : sum_adj[RMT_DATA_W:1];

    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        drop_next  = drop_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    drop_next  = full;
                    count_next = full ? occ_count : occ_count + CW'(1);
                    state_next = ST_PICK;
                end
            end
            ST_PICK: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            drop_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            drop_reg    <= drop_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign cnt_ext = {{RMT_CNT_OUT_W{1'b0}}, count_reg};

    always_ff @(posedge aclk) begin
        if (state_reg == ST_PICK) begin
            lo_reg <= lo_sel;
            hi_reg <= hi_sel;
        end
        if (out_load) begin
            med_reg      <= med_calc;
            cnt_out_reg  <= cnt_ext[RMT_CNT_OUT_W-1:0];
            drop_out_reg <= drop_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {drop_out_reg, cnt_out_reg, med_reg};

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - running_median_tracker testbench
// A directed table covers the extreme samples, truncation of even-count
// means, duplicates, a full store and a restart on a full store. Random runs
// of samples follow, each opened by a restart. Rows with a result are held to
// it, others to an in-bench sorted-store tracker; both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    import rmt_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 420;
    localparam int QUIET_ITEMS  = 60;
    localparam int DRAIN_CYCLES = 12;
    localparam int STALL_LIMIT  = 2000;
    localparam int MAX_REPORTS  = 100;
    localparam int DIR_ROWS     = 23;

    typedef struct packed {
        logic                     dropped;
        logic [RMT_CNT_OUT_W-1:0] stored_count;
        rmt_data_t                median;
    } median_result_t;

    typedef struct packed {
        rmt_data_t      sample;
        logic           restart;
        logic [7:0]     reps;
        logic           typed;
        median_result_t result;
    } stim_row_t;

    localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
        '{32'sd5,         1'b0, 8'd1,  1'b1, '{1'b0, 7'd1,  32'sd5}},
        '{32'sh7fffffff,  1'b1, 8'd1,  1'b1, '{1'b0, 7'd1,  32'sh7fffffff}},
        '{32'sh80000000,  1'b0, 8'd1,  1'b1, '{1'b0, 7'd2,  32'sd0}},
        '{32'sh80000000,  1'b0, 8'd1,  1'b1, '{1'b0, 7'd3,  32'sh80000000}},
        '{32'sh80000000,  1'b1, 8'd1,  1'b1, '{1'b0, 7'd1,  32'sh80000000}},
        '{32'sh80000000,  1'b0, 8'd1,  1'b1, '{1'b0, 7'd2,  32'sh80000000}},
        '{-32'sd3,        1'b1, 8'd1,  1'b1, '{1'b0, 7'd1,  -32'sd3}},
        '{-32'sd4,        1'b0, 8'd1,  1'b1, '{1'b0, 7'd2,  -32'sd3}},
        '{32'sd4,         1'b0, 8'd1,  1'b0, '0},
        '{32'sd0,         1'b0, 8'd1,  1'b0, '0},
        '{-32'sd1,        1'b0, 8'd1,  1'b0, '0},
        '{32'sd1,         1'b0, 8'd1,  1'b0, '0},
        '{32'sh7fffffff,  1'b1, 8'd1,  1'b1, '{1'b0, 7'd1,  32'sh7fffffff}},
        '{32'sh7fffffff,  1'b0, 8'd1,  1'b1, '{1'b0, 7'd2,  32'sh7fffffff}},
        '{32'sd9,         1'b1, 8'd1,  1'b0, '0},
        '{32'sd9,         1'b0, 8'd2,  1'b0, '0},
        '{32'sd100,       1'b1, 8'd1,  1'b1, '{1'b0, 7'd1,  32'sd100}},
        '{32'sd100,       1'b0, 8'd63, 1'b0, '0},
        '{32'sd7,         1'b0, 8'd1,  1'b1, '{1'b1, 7'd64, 32'sd100}},
        '{32'sh80000000,  1'b0, 8'd1,  1'b1, '{1'b1, 7'd64, 32'sd100}},
        '{-32'sd3,        1'b1, 8'd1,  1'b1, '{1'b0, 7'd1,  -32'sd3}},
        '{32'sh55555555,  1'b0, 8'd1,  1'b0, '0},
        '{32'shaaaaaaaa,  1'b0, 8'd1,  1'b0, '0}
    };

    logic                     aclk     = 1'b0;
    logic                     aresetn  = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [RMT_S_TDATA_W-1:0] s_tdata  = '0;  // sample, restart
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [RMT_M_TDATA_W-1:0] m_tdata;        // median, stored_count, dropped

    logic           quiet       = 1'b0;
    logic           row_typed   = 1'b0;
    median_result_t row_result  = '0;
    int             idle_cycles = 0;
    int             error_count = 0;

    rmt_data_t      sorted_vals[$];
    median_result_t expected_medians[$];

    running_median_tracker i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #CLK_HALF aclk = ~aclk;

    function automatic median_result_t track_median(rmt_data_t smp, logic rst);
        median_result_t r;
        int             pos;
        int             n;
        longint signed  pair_sum;
        longint signed  pair_mean;
        if (rst) begin
            sorted_vals.delete();
        end
        r.dropped = (sorted_vals.size() >= RMT_CAPACITY);
        if (!r.dropped) begin
            pos = 0;
            while (pos < sorted_vals.size() && sorted_vals[pos] <= smp)
                pos++;
            sorted_vals.insert(pos, smp);
        end
        n = sorted_vals.size();
        if (n % 2 == 1) begin
            r.median = sorted_vals[n / 2];
        end else begin
            pair_sum  = longint'(sorted_vals[n / 2 - 1]) + longint'(sorted_vals[n / 2]);
            pair_mean = pair_sum / 2;
            r.median  = pair_mean[31:0];
        end
        r.stored_count = n[RMT_CNT_OUT_W-1:0];
        return r;
    endfunction

    task automatic flag_mismatch(string what, longint want, longint got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endtask

    task automatic idle_input();
        if (!quiet && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 13)) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
        end
    endtask

    task automatic send_sample(rmt_data_t smp, logic rst, logic typed, median_result_t res);
        logic [RMT_S_TDATA_W-1:0] word;
        word      = '0;
        word[31:0] = smp;
        word[32]  = rst;
        @(negedge aclk);
        row_typed  = typed;
        row_result = res;
        s_tvalid  <= 1'b1;
        s_tdata   <= word;
        do @(posedge aclk); while (!s_tready);
    endtask

    always @(posedge aclk) begin
        median_result_t got;
        median_result_t want;
        median_result_t pred;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                pred = track_median(s_tdata[31:0], s_tdata[32]);
                expected_medians.push_back(row_typed ? row_result : pred);
            end
            if (m_tvalid && m_tready) begin
                got = median_result_t'(m_tdata);
                if (expected_medians.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: unexpected transaction, expected none, actual %h",
                                 $time, m_tdata);
                end else begin
                    want = expected_medians.pop_front();
                    if (got.median !== want.median)
                        flag_mismatch("median", want.median, got.median);
                    if (got.stored_count !== want.stored_count)
                        flag_mismatch("stored_count", want.stored_count, got.stored_count);
                    if (got.dropped !== want.dropped)
                        flag_mismatch("dropped", want.dropped, got.dropped);
                end
            end
            idle_cycles <= ((s_tvalid && s_tready) || (m_tvalid && m_tready)) ?
                           0 : idle_cycles + 1;
        end
    end

    initial begin
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 13)) begin
                    @(negedge aclk);
                    m_tready <= 1'b0;
                end
            end else begin
                @(negedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        do @(posedge aclk); while (idle_cycles < STALL_LIMIT);
        $display("** running_median_tracker: FAILED **");
        $finish;
    end

    initial begin
        int        i;
        int        k;
        int        items;
        int        seg_len;
        int        mode;
        rmt_data_t smp;
        rmt_data_t prev;
        logic      rst;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < DIR_ROWS; i++) begin
            for (k = 0; k < DIR_TABLE[i].reps; k++) begin
                idle_input();
                send_sample(DIR_TABLE[i].sample, DIR_TABLE[i].restart,
                            DIR_TABLE[i].typed, DIR_TABLE[i].result);
            end
        end

        // runs of random length; some long enough to fill the store and drop
        items = 0;
        prev  = '0;
        while (items < RANDOM_ITEMS) begin
            seg_len = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 90)
                                                  : $urandom_range(1, 40);
            mode = $urandom_range(0, 3);
            for (k = 0; k < seg_len && items < RANDOM_ITEMS; k++) begin
                case (mode)
                    0: smp = $urandom;
                    1: smp = $signed($urandom_range(0, 16)) - 8;
                    2: smp = $urandom_range(0, 1) ? 32'sh7fffffff - $urandom_range(0, 3)
                                                  : 32'sh80000000 + $urandom_range(0, 3);
                    default: smp = $urandom_range(0, 1) ? prev : $urandom;
                endcase
                prev  = smp;
                rst   = (k == 0) || ($urandom_range(0, 63) == 0);
                quiet = (items >= RANDOM_ITEMS - QUIET_ITEMS);
                idle_input();
                send_sample(smp, rst, 1'b0, '0);
                items++;
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_medians.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("** running_median_tracker: PASSED **");
        end else begin
            $display("** running_median_tracker: FAILED **");
        end
        $finish;
    end

endmodule
